// File: rtl/core/les_pkg.sv
package les_pkg;

  // item operation codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_PLAY = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_LOAD = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_COUNT = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // most events one tick may emit
  localparam int unsigned MAX_EMIT = 64;

  // input word
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] time_code;
    logic        immediately;
    logic [5:0]  load_index;
    logic [15:0] load_time;
    logic [23:0] load_message;
  } les_in_t;

  // result word
  typedef struct packed {
    logic        has_event;
    logic [23:0] midi_message;
    logic        started;
    logic        playing;
    logic        last;
  } les_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic div_step;
    logic boundary;
    logic rd;
    logic advance;
    logic consume;
    logic emit_event;
    logic emit_last;
    logic emit_plain;
    logic finish;
  } les_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic div_done;
    logic playing;
    logic walk_more;
    logic match;
    logic pending;
    logic out_free;
  } les_sts_t;

endpackage

// File: rtl/core/les_ram.sv
module les_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/les_datapath.sv
module les_datapath #(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned TIME_WIDTH    = 16,
  parameter int unsigned MESSAGE_WIDTH = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  les_pkg::les_in_t                   in_word_i,
  input  logic                               cfg_we_i,
  input  logic [les_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [les_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  les_pkg::les_cmd_t                  cmd_i,
  output les_pkg::les_sts_t                  sts_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output les_pkg::les_out_t                  out_word_o
);
  import les_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned RW = TIME_WIDTH + MESSAGE_WIDTH;

  logic [15:0]              loop_length_q;
  logic [6:0]               event_count_q;
  logic [IW-1:0]            rp_q, p_q;
  logic                     wait_play_q, wait_stop_q, playing_q, started_q;
  logic                     walking_q, pend_valid_q;
  logic [6:0]               k_q;
  logic [4:0]               div_cnt_q;
  logic [31:0]              tc_q;
  logic [15:0]              rem_q;
  logic [MESSAGE_WIDTH-1:0] pend_msg_q;
  logic                     out_valid_q;
  les_out_t                 out_word_q;

  logic [15:0]              len;
  logic [16:0]              div_trial, div_diff;
  logic [15:0]              rem_next;
  logic [31:0]              cnt32, n32, p32, rp32, time32, pos32, k32;
  logic                     time_lt, time_eq, p_is_last, k_room, walk_more, match;
  logic [IW-1:0]            p_wrap;
  logic                     ram_we;
  logic [RW-1:0]            ram_wdata, ram_rdata;
  logic [31:0]              ld_time_ext, ld_msg_ext, pend_msg_ext;
  logic [TIME_WIDTH-1:0]    rd_time;
  logic [MESSAGE_WIDTH-1:0] rd_msg;
  logic                     out_free;

  // event table
  assign ld_time_ext = 32'(in_word_i.load_time);
  assign ld_msg_ext  = 32'(in_word_i.load_message);
  assign ram_we      = cmd_i.take && (in_word_i.op == OP_LOAD) &&
                       (32'(in_word_i.load_index) < TABLE_DEPTH);
  assign ram_wdata   = {ld_time_ext[TIME_WIDTH-1:0], ld_msg_ext[MESSAGE_WIDTH-1:0]};

  les_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IW'(in_word_i.load_index)),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (p_q),
    .rdata_o (ram_rdata)
  );

  assign rd_time = ram_rdata[RW-1:MESSAGE_WIDTH];
  assign rd_msg  = ram_rdata[MESSAGE_WIDTH-1:0];

  // restoring modulo step, one quotient bit per cycle
  assign len       = (loop_length_q == 16'd0) ? 16'd1 : loop_length_q;
  assign div_trial = {rem_q, tc_q[31]};
  assign div_diff  = div_trial - {1'b0, len};
  assign rem_next  = (div_trial >= {1'b0, len}) ? div_diff[15:0] : div_trial[15:0];

  // effective entry count, saturated to the table, zero acting as one
  assign cnt32 = 32'(event_count_q);
  always_comb begin
    if (cnt32 == 32'd0) begin
      n32 = 32'd1;
    end else if (cnt32 > TABLE_DEPTH) begin
      n32 = TABLE_DEPTH;
    end else begin
      n32 = cnt32;
    end
  end

  // walk and match conditions on the entry just read
  assign p32       = 32'(p_q);
  assign rp32      = 32'(rp_q);
  assign time32    = 32'(rd_time);
  assign pos32     = 32'(rem_q);
  assign k32       = 32'(k_q);
  assign time_lt   = time32 < pos32;
  assign time_eq   = time32 == pos32;
  assign p_is_last = p32 == (n32 - 32'd1);
  assign p_wrap    = p_is_last ? '0 : p_q + 1'b1;
  assign k_room    = (k32 < n32) && (k32 < MAX_EMIT);
  assign walk_more = walking_q && !p_is_last && time_lt;
  assign match     = k_room && time_eq;

  assign out_free  = !out_valid_q || !out_stall_i;

  // control and track state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_length_q <= 16'd1;
      event_count_q <= 7'd1;
      rp_q          <= '0;
      p_q           <= '0;
      wait_play_q   <= 1'b0;
      wait_stop_q   <= 1'b0;
      playing_q     <= 1'b0;
      started_q     <= 1'b0;
      walking_q     <= 1'b0;
      pend_valid_q  <= 1'b0;
      k_q           <= '0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LOOP_LENGTH: loop_length_q <= cfg_data_i;
          CFG_EVENT_COUNT: event_count_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        started_q <= 1'b0;
        div_cnt_q <= '0;
        unique case (in_word_i.op)
          OP_PLAY: begin
            if (in_word_i.immediately) begin
              playing_q   <= 1'b1;
              wait_play_q <= 1'b0;
            end else begin
              wait_play_q <= 1'b1;
            end
            wait_stop_q <= 1'b0;
          end
          OP_STOP: begin
            if (in_word_i.immediately) begin
              playing_q   <= 1'b0;
              wait_stop_q <= 1'b0;
            end else begin
              wait_stop_q <= 1'b1;
            end
            wait_play_q <= 1'b0;
          end
          OP_TICK, OP_LOAD: ;
          default: ;
        endcase
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 5'd1;
      end
      // loop start: pending play wins over pending stop
      if (cmd_i.boundary) begin
        if (rem_q == 16'd0) begin
          if (wait_play_q) begin
            playing_q   <= 1'b1;
            wait_play_q <= 1'b0;
            started_q   <= 1'b1;
          end else if (wait_stop_q) begin
            playing_q   <= 1'b0;
            wait_stop_q <= 1'b0;
          end
        end
        p_q          <= (rp32 >= n32) ? '0 : rp_q;
        walking_q    <= 1'b1;
        pend_valid_q <= 1'b0;
        k_q          <= '0;
      end
      if (cmd_i.advance) begin
        p_q <= p_q + 1'b1;
      end
      if (cmd_i.consume) begin
        pend_valid_q <= 1'b1;
        k_q          <= k_q + 7'd1;
        p_q          <= p_wrap;
        walking_q    <= 1'b0;
      end
      // finished track returns to the first entry
      if (cmd_i.finish) begin
        rp_q <= (p_is_last && time_lt) ? '0 : p_q;
      end
      if (cmd_i.emit_event || cmd_i.emit_plain) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  assign pend_msg_ext = 32'(pend_msg_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      tc_q  <= in_word_i.time_code;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      tc_q  <= {tc_q[30:0], 1'b0};
      rem_q <= rem_next;
    end
    if (cmd_i.consume) begin
      pend_msg_q <= rd_msg;
    end
    if (cmd_i.emit_event) begin
      out_word_q.has_event    <= 1'b1;
      out_word_q.midi_message <= pend_msg_ext[23:0];
      out_word_q.started      <= started_q;
      out_word_q.playing      <= playing_q;
      out_word_q.last         <= cmd_i.emit_last;
    end else if (cmd_i.emit_plain) begin
      out_word_q.has_event    <= 1'b0;
      out_word_q.midi_message <= '0;
      out_word_q.started      <= started_q;
      out_word_q.playing      <= playing_q;
      out_word_q.last         <= 1'b1;
    end
  end

  // status back to the controller
  assign sts_o.is_tick   = in_word_i.op == OP_TICK;
  assign sts_o.div_done  = div_cnt_q == 5'd31;
  assign sts_o.playing   = playing_q;
  assign sts_o.walk_more = walk_more;
  assign sts_o.match     = match;
  assign sts_o.pending   = pend_valid_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: rtl/core/les_ctrl.sv
module les_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  les_pkg::les_sts_t sts_i,
  output les_pkg::les_cmd_t cmd_o
);
  import les_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REPLY = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_BOUND = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;

  logic [2:0] state_q, state_d;

  // sequencing of one item
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.is_tick ? S_DIV : S_REPLY;
        end
      end
      S_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_plain = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_BOUND;
        end
      end
      S_BOUND: begin
        cmd_o.boundary = 1'b1;
        state_d        = S_START;
      end
      S_START: begin
        if (sts_i.playing) begin
          cmd_o.rd = 1'b1;
          state_d  = S_CHECK;
        end else begin
          state_d = S_REPLY;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.walk_more) begin
          cmd_o.advance = 1'b1;
          state_d       = S_RD;
        end else if (sts_i.match && !sts_i.pending) begin
          cmd_o.consume = 1'b1;
          state_d       = S_RD;
        end else if (sts_i.match) begin
          // another event follows, so the held one is not the last
          if (sts_i.out_free) begin
            cmd_o.emit_event = 1'b1;
            cmd_o.consume    = 1'b1;
            state_d          = S_RD;
          end
        end else if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          if (sts_i.pending) begin
            cmd_o.emit_event = 1'b1;
            cmd_o.emit_last  = 1'b1;
          end else begin
            cmd_o.emit_plain = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

// File: rtl/core/loop_event_sequencer.sv
// play, stop and load words: one result, issued once the output register is free
// tick words: serial modulo and setup, then a table read for each entry walked past
//   or emitted, and a last step to issue the final result
// one word is in flight at a time; the next is taken once the last result is issued
// reset (async, active low) clears play state, read pointer and output valid, sets
//   loop_length and event_count to 1; the event table holds nothing until loaded
module loop_event_sequencer #(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned TIME_WIDTH    = 16,
  parameter int unsigned MESSAGE_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  les_pkg::les_in_t                in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output les_pkg::les_out_t               out_word_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [les_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [les_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import les_pkg::*;

  les_cmd_t cmd;
  les_sts_t sts;

  assign cfg_ready_o = 1'b1;

  les_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  les_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH),
    .MESSAGE_WIDTH (MESSAGE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // a word without an event carries no message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.has_event |-> out_word_o.midi_message == '0)
    else $error("empty result carries a message");

  // only event results may be followed by more results of the same word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> out_word_o.has_event)
    else $error("non-final result without event");

  // a quantized start leaves the track playing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.started |-> out_word_o.playing)
    else $error("started without playing");

  // one word in flight: taking a word closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import les_pkg::*;

  localparam int unsigned TRACK_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // block ports
  logic                   in_valid = 1'b0;
  logic                   in_stall_o;
  les_in_t                in_word = '0;
  logic                   out_valid_o;
  logic                   out_stall = 1'b0;
  les_out_t               out_word_o;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  loop_event_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // track state mirrored from the block
  logic [15:0] trk_time [TRACK_DEPTH];
  logic [23:0] trk_msg  [TRACK_DEPTH];
  int unsigned trk_ptr = 0;
  logic        trk_playing = 1'b0;
  logic        trk_wait_play = 1'b0;
  logic        trk_wait_stop = 1'b0;
  logic [15:0] trk_len = 16'd1;
  logic [6:0]  trk_count = 7'd1;

  // result words the track should produce, oldest first
  les_out_t track_results [$];

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int unsigned cycle_count = 0;
  int unsigned clock_code = 0;

  // run one word through the mirrored track and queue its result words
  task automatic step_track(input les_in_t w);
    les_out_t    r;
    logic [23:0] hits [$];
    int unsigned span;
    int unsigned pos;
    int unsigned n;
    int unsigned p;
    logic        began;
    r = '0;
    began = 1'b0;
    case (w.op)
      OP_PLAY: begin
        if (w.immediately) begin
          trk_playing = 1'b1;
          trk_wait_play = 1'b0;
        end else begin
          trk_wait_play = 1'b1;
        end
        trk_wait_stop = 1'b0;
      end
      OP_STOP: begin
        if (w.immediately) begin
          trk_playing = 1'b0;
          trk_wait_stop = 1'b0;
        end else begin
          trk_wait_stop = 1'b1;
        end
        trk_wait_play = 1'b0;
      end
      OP_LOAD: begin
        trk_time[w.load_index] = w.load_time;
        trk_msg[w.load_index] = w.load_message;
      end
      default: ;
    endcase
    if (w.op != OP_TICK) begin
      r.playing = trk_playing;
      r.last = 1'b1;
      track_results = {track_results, r};
    end else begin
      span = (trk_len == 0) ? 1 : trk_len;
      pos = w.time_code % span;
      n = (trk_count == 0) ? 1 : trk_count;
      if (n > TRACK_DEPTH) n = TRACK_DEPTH;
      // quantized transport at loop start, pending play first
      if (pos == 0) begin
        if (trk_wait_play) begin
          trk_playing = 1'b1;
          trk_wait_play = 1'b0;
          began = 1'b1;
        end else if (trk_wait_stop) begin
          trk_playing = 1'b0;
          trk_wait_stop = 1'b0;
        end
      end
      // walk past earlier events, then collect the ones at this position
      if (trk_playing) begin
        p = trk_ptr;
        if (p >= n) p = 0;
        while (p != n - 1 && trk_time[p] < pos) p++;
        while (hits.size() < n && trk_time[p] == pos) begin
          hits = {hits, trk_msg[p]};
          p = (p + 1 == n) ? 0 : p + 1;
        end
        if (p == n - 1 && trk_time[p] < pos) p = 0;
        trk_ptr = p;
      end
      r.started = began;
      r.playing = trk_playing;
      if (hits.size() == 0) begin
        r.last = 1'b1;
        track_results = {track_results, r};
      end else begin
        foreach (hits[i]) begin
          r.has_event = 1'b1;
          r.midi_message = hits[i];
          r.last = (i == hits.size() - 1);
          track_results = {track_results, r};
        end
      end
    end
  endtask

  // send one word, with random idle cycles ahead of it
  task automatic send_word(input les_in_t w);
    int gaps;
    gaps = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gaps < 16) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    step_track(w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // word with random content in the fields the op does not use
  function automatic les_in_t filler(input logic [1:0] op);
    les_in_t w;
    w.op = op;
    w.time_code = $urandom;
    w.immediately = 1'($urandom_range(1));
    w.load_index = 6'($urandom_range(63));
    w.load_time = 16'($urandom_range(16'hFFFF));
    w.load_message = 24'($urandom_range(24'hFFFFFF));
    return w;
  endfunction

  task automatic do_tick(input logic [31:0] tc);
    les_in_t w;
    w = filler(OP_TICK);
    w.time_code = tc;
    send_word(w);
  endtask

  task automatic do_transport(input logic [1:0] op, input logic imm);
    les_in_t w;
    w = filler(op);
    w.immediately = imm;
    send_word(w);
  endtask

  task automatic do_load(input logic [5:0] idx, input logic [15:0] t,
                         input logic [23:0] msg);
    les_in_t w;
    w = filler(OP_LOAD);
    w.load_index = idx;
    w.load_time = t;
    w.load_message = msg;
    send_word(w);
  endtask

  // hold off the sender until every queued result word has come out
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (track_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOOP_LENGTH) trk_len = val;
    else if (idx == CFG_EVENT_COUNT) trk_count = val[6:0];
    @(posedge clk_i);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each result word with the oldest queued one
  always @(posedge clk_i) begin
    les_out_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (track_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result word: %0b/%06h/%0b/%0b/%0b",
                   out_word_o.has_event, out_word_o.midi_message, out_word_o.started,
                   out_word_o.playing, out_word_o.last);
        errors++;
      end else begin
        want = track_results.pop_front();
        if (out_word_o.has_event !== want.has_event ||
            out_word_o.midi_message !== want.midi_message ||
            out_word_o.started !== want.started ||
            out_word_o.playing !== want.playing ||
            out_word_o.last !== want.last) begin
          if (errors < 10)
            $display("result mismatch: want %0b/%06h/%0b/%0b/%0b got %0b/%06h/%0b/%0b/%0b",
                     want.has_event, want.midi_message, want.started, want.playing,
                     want.last, out_word_o.has_event, out_word_o.midi_message,
                     out_word_o.started, out_word_o.playing, out_word_o.last);
          errors++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("loop_event_sequencer regression: fail");
      $finish;
    end
  end

  // small table: transport modes, wraps, shrinking count
  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    do_load(6'd0, 16'd0, 24'hFFFFFF);
    do_tick(32'd0);
    do_transport(OP_PLAY, 1'b1);
    do_tick(32'hFFFF_FFFF);
    do_load(6'd63, 16'hFFFF, 24'h000000);
    // zero loop length acts as one
    wait_results_done();
    write_reg(CFG_LOOP_LENGTH, 16'd0);
    do_tick(32'd12345);
    do_load(6'd1, 16'd0, 24'h903C7F);
    do_load(6'd2, 16'd5, 24'h803C00);
    do_load(6'd3, 16'd9, 24'h904060);
    do_load(6'd4, 16'd20, 24'h804000);
    wait_results_done();
    write_reg(CFG_LOOP_LENGTH, 16'd16);
    write_reg(CFG_EVENT_COUNT, 16'd4);
    // walk, wrap after the last entry, track finished, two events at loop start
    do_tick(32'd3);
    do_tick(32'd5);
    do_tick(32'd9);
    do_tick(32'd12);
    do_tick(32'd16);
    // deferred play and stop, each clearing the other
    do_transport(OP_STOP, 1'b1);
    do_transport(OP_PLAY, 1'b0);
    do_tick(32'd19);
    do_tick(32'd32);
    do_transport(OP_STOP, 1'b0);
    do_transport(OP_PLAY, 1'b0);
    do_tick(32'd48);
    do_transport(OP_STOP, 1'b0);
    do_tick(32'd21);
    do_tick(32'd64);
    do_transport(OP_PLAY, 1'b1);
    // entry at or past loop length, then pointer left past a shrunk count
    wait_results_done();
    write_reg(CFG_EVENT_COUNT, 16'd5);
    do_tick(32'd41);
    do_tick(32'd47);
    wait_results_done();
    write_reg(CFG_EVENT_COUNT, 16'd2);
    do_tick(32'd50);
    wait_results_done();
  endtask

  // full table: most events per tick, count saturation and masking, longest loop
  task automatic test_full_table();
    idle_pct = 31;
    stall_pct = 31;
    for (int i = 0; i < TRACK_DEPTH; i++) do_load(6'(i), 16'd7, 24'($urandom));
    wait_results_done();
    write_reg(CFG_LOOP_LENGTH, 16'hFFFF);
    write_reg(CFG_EVENT_COUNT, 16'd64);
    do_transport(OP_PLAY, 1'b1);
    do_tick(32'd7);
    do_tick(32'd65542);
    do_tick(32'd65535);
    wait_results_done();
    write_reg(CFG_EVENT_COUNT, 16'd100);
    do_tick(32'd7);
    // spread table with its last entry beyond the loop
    for (int i = 0; i < 16; i++)
      do_load(6'(i), (i == 15) ? 16'hFFFF : 16'(i * 4000), 24'($urandom));
    wait_results_done();
    write_reg(CFG_EVENT_COUNT, 16'd16);
    do_tick(32'd5000);
    do_tick(32'd62500);
    do_tick(32'd65534);
    do_tick(32'd131070);
    // count written as zero in its low bits acts as one
    wait_results_done();
    write_reg(CFG_EVENT_COUNT, 16'hFF80);
    do_tick(32'd196605);
    wait_results_done();
    write_reg(CFG_LOOP_LENGTH, 16'd0);
    do_tick($urandom);
    wait_results_done();
  endtask

  // sorted table, running time code, mixed with transport and stray loads
  task automatic test_random_phase(input int sender_pct, input int recv_pct, input int count);
    int unsigned span;
    int unsigned n;
    int unsigned n_load;
    int unsigned t;
    int unsigned step_max;
    int          r;
    idle_pct = sender_pct;
    stall_pct = recv_pct;
    case ($urandom_range(4))
      0: span = $urandom_range(1, 8);
      1: span = $urandom_range(9, 100);
      2: span = $urandom_range(101, 65535);
      3: span = $urandom_range(1, 30);
      default: span = ($urandom_range(1)) ? 0 : 65535;
    endcase
    r = $urandom_range(99);
    if (r < 80) n = $urandom_range(1, 8);
    else if (r < 95) n = $urandom_range(9, 32);
    else n = $urandom_range(0, 127);
    n_load = (n == 0) ? 1 : (n > TRACK_DEPTH) ? TRACK_DEPTH : n;
    step_max = ((span == 0 ? 1 : span) / n_load) + 1;
    t = $urandom_range(1);
    for (int i = 0; i < n_load; i++) begin
      do_load(6'(i), (t > 16'hFFFF) ? 16'hFFFF : 16'(t), 24'($urandom));
      t = t + $urandom_range(0, step_max);
    end
    wait_results_done();
    write_reg(CFG_LOOP_LENGTH, 16'(span));
    write_reg(CFG_EVENT_COUNT, (16'($urandom) & 16'hFF80) | 16'(n));
    span = (span == 0) ? 1 : span;
    clock_code = $urandom;
    do_transport(OP_PLAY, 1'($urandom_range(1)));
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_results_done();
      r = $urandom_range(99);
      if (r < 75) begin
        r = $urandom_range(99);
        if (r < 60) clock_code = clock_code + 1;
        else if (r < 80)
          clock_code = clock_code - (clock_code % span) + span +
                       trk_time[$urandom_range(n_load - 1)];
        else if (r < 92) clock_code = clock_code - (clock_code % span) + span;
        else clock_code = $urandom;
        do_tick(clock_code);
      end else if (r < 83) begin
        do_transport(OP_PLAY, 1'($urandom_range(1)));
      end else if (r < 90) begin
        do_transport(OP_STOP, 1'($urandom_range(1)));
      end else begin
        do_load(6'($urandom_range(63)), 16'($urandom_range(16'hFFFF)),
                24'($urandom_range(24'hFFFFFF)));
      end
    end
    wait_results_done();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random_phase(0, 0, 10);
    test_random_phase(51, 0, 10);
    test_random_phase(0, 51, 10);
    test_random_phase(31, 31, 10);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && track_results.size() == 0) begin
      $display("loop_event_sequencer regression: pass");
    end else begin
      $display("loop_event_sequencer regression: fail");
    end
    $finish;
  end

endmodule
